// ===== sv/twqa_pkg.sv =====
// package: shared constants, codes and types for the two-lane weighted queue arbiter
`default_nettype none

package twqa_pkg;

    localparam int LIVE_DEPTH    = 64;
    localparam int REBUILD_DEPTH = 256;
    localparam int PAYLOAD_BITS  = 32;

    localparam int LIVE_AW = $clog2(LIVE_DEPTH);
    localparam int LIVE_CW = $clog2(LIVE_DEPTH + 1);
    localparam int LIVE_SW = LIVE_CW + 1;
    localparam int REB_AW  = $clog2(REBUILD_DEPTH);
    localparam int REB_CW  = $clog2(REBUILD_DEPTH + 1);
    localparam int REB_SW  = REB_CW + 1;

    localparam int SLOT_MOD  = 100;
    localparam int SHARE_MAX = 99;
    localparam int SLOT_W    = $clog2(SLOT_MOD);

    localparam int NUM_CTR    = 10;
    localparam int CTR_W      = 32;
    localparam int STAT_IDX_W = 4;

    localparam int CMD_W        = 3;
    localparam int REASON_W     = 2;
    localparam int LIVE_CAP_W   = 7;
    localparam int REB_CAP_W    = 9;
    localparam int SHARE_W      = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 9;

    localparam logic [LIVE_CAP_W-1:0] LIVE_CAP_RST  = LIVE_CAP_W'(64);
    localparam logic [REB_CAP_W-1:0]  REB_CAP_RST   = REB_CAP_W'(256);
    localparam logic [SHARE_W-1:0]    SHARE_RST     = SHARE_W'(50);

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE   = 3'd0,
        CMD_DEQUEUE   = 3'd1,
        CMD_DROP      = 3'd2,
        CMD_COALESCED = 3'd3,
        CMD_STALE     = 3'd4,
        CMD_SHUTDOWN  = 3'd5,
        CMD_READ_STAT = 3'd6
    } cmd_t;

    typedef enum logic [REASON_W-1:0] {
        REASON_MEM_SOFT = 2'd0,
        REASON_MEM_HARD = 2'd1,
        REASON_LAG      = 2'd2,
        REASON_FULL     = 2'd3
    } reason_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIVE_CAP    = 2'd0,
        CFG_REBUILD_CAP = 2'd1,
        CFG_LIVE_SHARE  = 2'd2
    } cfg_reg_t;

    localparam int CTR_DROP_LIVE    = 0;
    localparam int CTR_DROP_REBUILD = 1;
    localparam int CTR_DROP_FULL    = 2;
    localparam int CTR_DROP_SOFT    = 3;
    localparam int CTR_DROP_HARD    = 4;
    localparam int CTR_DROP_LAG     = 5;
    localparam int CTR_STALE        = 6;
    localparam int CTR_COALESCED    = 7;
    localparam int CTR_DISP_LIVE    = 8;
    localparam int CTR_DISP_REBUILD = 9;

    typedef struct packed {
        logic drop_live;
        logic drop_rebuild;
        logic drop_full;
        logic drop_soft;
        logic drop_hard;
        logic drop_lag;
        logic stale;
        logic coalesced;
        logic disp_live;
        logic disp_rebuild;
    } bump_t;

endpackage

`default_nettype wire

// ===== sv/twqa_if.sv =====
// interfaces: command, response and configuration channels
`default_nettype none

interface twqa_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [twqa_pkg::CMD_W-1:0]            command;
    logic                                  lane;
    logic [twqa_pkg::PAYLOAD_BITS-1:0]     payload;
    logic [twqa_pkg::REASON_W-1:0]         drop_reason;
    logic [twqa_pkg::STAT_IDX_W-1:0]       stat_index;

    modport source (output valid, command, lane, payload, drop_reason, stat_index,
                    input ready);
    modport sink   (input valid, command, lane, payload, drop_reason, stat_index,
                    output ready);
endinterface

interface twqa_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  ok;
    logic                                  lane_out;
    logic [twqa_pkg::PAYLOAD_BITS-1:0]     payload_out;
    logic [twqa_pkg::CTR_W-1:0]            stat_value;
    logic [twqa_pkg::LIVE_CW-1:0]          live_count;
    logic [twqa_pkg::REB_CW-1:0]           rebuild_count;

    modport source (output valid, ok, lane_out, payload_out, stat_value, live_count,
                    rebuild_count, input ready);
    modport sink   (input valid, ok, lane_out, payload_out, stat_value, live_count,
                    rebuild_count, output ready);
endinterface

interface twqa_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [twqa_pkg::CFG_IDX_W-1:0]        index;
    logic [twqa_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/twqa_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module twqa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/twqa_stats.sv =====
// event counter bank: ten wrapping 32-bit counters with one read port
`default_nettype none

module twqa_stats (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire twqa_pkg::bump_t                     bump,
    input  wire logic [twqa_pkg::STAT_IDX_W-1:0]     rd_index,
    output logic      [twqa_pkg::CTR_W-1:0]          rd_value
);

    import twqa_pkg::*;

    logic [NUM_CTR-1:0] inc;
    logic [CTR_W-1:0]   ctr_reg [NUM_CTR];

    always_comb
    begin
        inc                   = '0;
        inc[CTR_DROP_LIVE]    = bump.drop_live;
        inc[CTR_DROP_REBUILD] = bump.drop_rebuild;
        inc[CTR_DROP_FULL]    = bump.drop_full;
        inc[CTR_DROP_SOFT]    = bump.drop_soft;
        inc[CTR_DROP_HARD]    = bump.drop_hard;
        inc[CTR_DROP_LAG]     = bump.drop_lag;
        inc[CTR_STALE]        = bump.stale;
        inc[CTR_COALESCED]    = bump.coalesced;
        inc[CTR_DISP_LIVE]    = bump.disp_live;
        inc[CTR_DISP_REBUILD] = bump.disp_rebuild;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CTR; i++)
            begin
                ctr_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CTR; i++)
            begin
                if (inc[i])
                begin
                    ctr_reg[i] <= ctr_reg[i] + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        rd_value = '0;
        for (int i = 0; i < NUM_CTR; i++)
        begin
            if (rd_index == STAT_IDX_W'(i))
            begin
                rd_value = ctr_reg[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/two_lane_weighted_queue_arbiter.sv =====
// Two-lane weighted queue arbiter: live and rebuild FIFO lanes with caps, a
// 100-slot weighted dispatcher for contested dequeues, and ten event counters.
// One command is taken per cycle unless a waiting response stalls it, and its single
// response appears in the response register on the next cycle (throughput one per
// cycle). All state is updated in the cycle a command is taken; the lane RAM
// read issued by a dequeue lands in the RAM's registered read port alongside
// the response register. A waiting response stalls new commands only while the
// response side holds ready low. Configuration writes are always ready and
// take effect on the next command.
`default_nettype none

module two_lane_weighted_queue_arbiter (
    input  wire logic   clk,
    input  wire logic   rst_n,
    twqa_cmd_if.sink    cmd,
    twqa_rsp_if.source  rsp,
    twqa_cfg_if.sink    cfg
);

    import twqa_pkg::*;

    // configuration
    logic [LIVE_CAP_W-1:0] live_cap_reg;
    logic [REB_CAP_W-1:0]  rebuild_cap_reg;
    logic [SHARE_W-1:0]    live_share_reg;

    // lane and dispatcher state
    logic [LIVE_AW-1:0] live_head_reg, live_head_next;
    logic [LIVE_CW-1:0] live_used_reg, live_used_next;
    logic [REB_AW-1:0]  rebuild_head_reg, rebuild_head_next;
    logic [REB_CW-1:0]  rebuild_used_reg, rebuild_used_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               halted_reg, halted_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // response register
    logic               ok_reg, ok_next;
    logic               deq_reg, deq_next;
    logic               lane_reg, lane_next;
    logic [CTR_W-1:0]   stat_reg, stat_next;
    logic [LIVE_CW-1:0] live_cnt_reg;
    logic [REB_CW-1:0]  rebuild_cnt_reg;

    logic accept;
    logic cfg_accept;

    logic [LIVE_CW-1:0] live_eff_cap;
    logic [REB_CW-1:0]  rebuild_eff_cap;
    logic [SHARE_W-1:0] share;
    logic [LIVE_SW-1:0] live_sum;
    logic [REB_SW-1:0]  rebuild_sum;
    logic [LIVE_AW-1:0] live_tail;
    logic [REB_AW-1:0]  rebuild_tail;

    logic live_we, live_re, rebuild_we, rebuild_re;
    logic [PAYLOAD_BITS-1:0] live_q, rebuild_q;

    bump_t            bump;
    logic [CTR_W-1:0] stat_rd;

    assign accept     = cmd.valid && cmd.ready;
    assign cfg_accept = cfg.valid && cfg.ready;
    assign cmd.ready  = !rsp_valid_reg || rsp.ready;
    assign cfg.ready  = 1'b1;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_cap_reg    <= LIVE_CAP_RST;
            rebuild_cap_reg <= REB_CAP_RST;
            live_share_reg  <= SHARE_RST;
        end
        else if (cfg_accept)
        begin
            unique case (cfg.index)
                CFG_LIVE_CAP:    live_cap_reg    <= cfg.data[LIVE_CAP_W-1:0];
                CFG_REBUILD_CAP: rebuild_cap_reg <= cfg.data[REB_CAP_W-1:0];
                CFG_LIVE_SHARE:  live_share_reg  <= cfg.data[SHARE_W-1:0];
                default:         ;
            endcase
        end
    end

    // effective caps, clamped share and write positions
    always_comb
    begin
        if (live_cap_reg == '0 || 32'(live_cap_reg) > LIVE_DEPTH)
        begin
            live_eff_cap = LIVE_CW'(LIVE_DEPTH);
        end
        else
        begin
            live_eff_cap = LIVE_CW'(live_cap_reg);
        end

        if (rebuild_cap_reg == '0 || 32'(rebuild_cap_reg) > REBUILD_DEPTH)
        begin
            rebuild_eff_cap = REB_CW'(REBUILD_DEPTH);
        end
        else
        begin
            rebuild_eff_cap = REB_CW'(rebuild_cap_reg);
        end

        priority if (live_share_reg == '0)
        begin
            share = SHARE_W'(1);
        end
        else if (32'(live_share_reg) > SHARE_MAX)
        begin
            share = SHARE_W'(SHARE_MAX);
        end
        else
        begin
            share = live_share_reg;
        end

        live_sum = LIVE_SW'(live_head_reg) + LIVE_SW'(live_used_reg);
        if (live_sum >= LIVE_SW'(LIVE_DEPTH))
        begin
            live_tail = LIVE_AW'(live_sum - LIVE_SW'(LIVE_DEPTH));
        end
        else
        begin
            live_tail = LIVE_AW'(live_sum);
        end

        rebuild_sum = REB_SW'(rebuild_head_reg) + REB_SW'(rebuild_used_reg);
        if (rebuild_sum >= REB_SW'(REBUILD_DEPTH))
        begin
            rebuild_tail = REB_AW'(rebuild_sum - REB_SW'(REBUILD_DEPTH));
        end
        else
        begin
            rebuild_tail = REB_AW'(rebuild_sum);
        end
    end

    // command decode and state update
    always_comb
    begin
        live_head_next    = live_head_reg;
        live_used_next    = live_used_reg;
        rebuild_head_next = rebuild_head_reg;
        rebuild_used_next = rebuild_used_reg;
        slot_next         = slot_reg;
        halted_next       = halted_reg;
        ok_next           = 1'b0;
        deq_next          = 1'b0;
        lane_next         = 1'b0;
        stat_next         = '0;
        live_we           = 1'b0;
        live_re           = 1'b0;
        rebuild_we        = 1'b0;
        rebuild_re        = 1'b0;
        bump              = '0;

        if (accept)
        begin
            unique case (cmd.command)
                CMD_ENQUEUE:
                begin
                    if (!halted_reg)
                    begin
                        if (!cmd.lane)
                        begin
                            if (live_used_reg >= live_eff_cap)
                            begin
                                bump.drop_live = 1'b1;
                                bump.drop_full = 1'b1;
                            end
                            else
                            begin
                                live_we        = 1'b1;
                                live_used_next = live_used_reg + 1'b1;
                                ok_next        = 1'b1;
                            end
                        end
                        else
                        begin
                            if (rebuild_used_reg >= rebuild_eff_cap)
                            begin
                                bump.drop_rebuild = 1'b1;
                                bump.drop_full    = 1'b1;
                            end
                            else
                            begin
                                rebuild_we        = 1'b1;
                                rebuild_used_next = rebuild_used_reg + 1'b1;
                                ok_next           = 1'b1;
                            end
                        end
                    end
                end
                CMD_DEQUEUE:
                begin
                    if (!halted_reg && (live_used_reg != '0 || rebuild_used_reg != '0))
                    begin
                        ok_next  = 1'b1;
                        deq_next = 1'b1;
                        priority if (live_used_reg == '0)
                        begin
                            lane_next = 1'b1;
                        end
                        else if (rebuild_used_reg == '0)
                        begin
                            lane_next = 1'b0;
                        end
                        else
                        begin
                            lane_next = !(SHARE_W'(slot_reg) < share);
                            slot_next = (slot_reg == SLOT_W'(SLOT_MOD - 1)) ? '0
                                                                            : slot_reg + 1'b1;
                        end

                        if (!lane_next)
                        begin
                            live_re        = 1'b1;
                            live_head_next = (live_head_reg == LIVE_AW'(LIVE_DEPTH - 1))
                                             ? '0 : live_head_reg + 1'b1;
                            live_used_next = live_used_reg - 1'b1;
                            bump.disp_live = 1'b1;
                        end
                        else
                        begin
                            rebuild_re        = 1'b1;
                            rebuild_head_next = (rebuild_head_reg == REB_AW'(REBUILD_DEPTH - 1))
                                                ? '0 : rebuild_head_reg + 1'b1;
                            rebuild_used_next = rebuild_used_reg - 1'b1;
                            bump.disp_rebuild = 1'b1;
                        end
                    end
                end
                CMD_DROP:
                begin
                    bump.drop_live    = !cmd.lane;
                    bump.drop_rebuild = cmd.lane;
                    unique case (cmd.drop_reason)
                        REASON_MEM_SOFT: bump.drop_soft = 1'b1;
                        REASON_MEM_HARD: bump.drop_hard = 1'b1;
                        REASON_LAG:      bump.drop_lag  = 1'b1;
                        REASON_FULL:     bump.drop_full = 1'b1;
                        default:         ;
                    endcase
                end
                CMD_COALESCED: bump.coalesced = 1'b1;
                CMD_STALE:     bump.stale     = 1'b1;
                CMD_SHUTDOWN:  halted_next    = 1'b1;
                CMD_READ_STAT: stat_next      = stat_rd;
                default:       ;
            endcase
        end

        rsp_valid_next = accept || (rsp_valid_reg && !rsp.ready);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_head_reg    <= '0;
            live_used_reg    <= '0;
            rebuild_head_reg <= '0;
            rebuild_used_reg <= '0;
            slot_reg         <= '0;
            halted_reg       <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            live_head_reg    <= live_head_next;
            live_used_reg    <= live_used_next;
            rebuild_head_reg <= rebuild_head_next;
            rebuild_used_reg <= rebuild_used_next;
            slot_reg         <= slot_next;
            halted_reg       <= halted_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    // response register, loaded on each command transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg          <= ok_next;
            deq_reg         <= deq_next;
            lane_reg        <= lane_next;
            stat_reg        <= stat_next;
            live_cnt_reg    <= live_used_next;
            rebuild_cnt_reg <= rebuild_used_next;
        end
    end

    twqa_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (LIVE_DEPTH)
    ) u_live_ram (
        .clk   (clk),
        .we    (live_we),
        .waddr (live_tail),
        .wdata (cmd.payload),
        .re    (live_re),
        .raddr (live_head_reg),
        .rdata (live_q)
    );

    twqa_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (REBUILD_DEPTH)
    ) u_rebuild_ram (
        .clk   (clk),
        .we    (rebuild_we),
        .waddr (rebuild_tail),
        .wdata (cmd.payload),
        .re    (rebuild_re),
        .raddr (rebuild_head_reg),
        .rdata (rebuild_q)
    );

    twqa_stats u_stats (
        .clk      (clk),
        .rst_n    (rst_n),
        .bump     (bump),
        .rd_index (cmd.stat_index),
        .rd_value (stat_rd)
    );

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.ok            = ok_reg;
    assign rsp.lane_out      = lane_reg;
    assign rsp.payload_out   = !deq_reg ? '0 : (lane_reg ? rebuild_q : live_q);
    assign rsp.stat_value    = stat_reg;
    assign rsp.live_count    = live_cnt_reg;
    assign rsp.rebuild_count = rebuild_cnt_reg;

    // lane fill never exceeds the lane depth
    a_live_fill: assert property (@(posedge clk) disable iff (!rst_n)
        32'(live_used_reg) <= LIVE_DEPTH && 32'(rebuild_used_reg) <= REBUILD_DEPTH)
        else $error("lane fill beyond depth");

    // dispatch slot stays inside its modulus
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(slot_reg) < SLOT_MOD)
        else $error("dispatch slot out of range");

    // after shutdown an enqueue or dequeue leaves the lanes untouched
    a_halt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg && accept
        && (cmd.command == CMD_ENQUEUE || cmd.command == CMD_DEQUEUE)
        |=> $stable(live_used_reg) && $stable(rebuild_used_reg)
            && $stable(live_head_reg) && $stable(rebuild_head_reg))
        else $error("lane state changed after shutdown");

    // the slot advances only on a contested dequeue
    a_slot_move: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && cmd.command == CMD_DEQUEUE && live_used_reg != '0
          && rebuild_used_reg != '0 && !halted_reg)
        |=> $stable(slot_reg))
        else $error("dispatch slot moved without a contested dequeue");

endmodule

`default_nettype wire
